@@ hw/rtl/cvf_pkg.sv @@
// cvf_pkg: shared types, constants and arithmetic helpers of the channel vocoder filter bank
// no dependencies
`default_nettype none
package cvf_pkg;

  localparam int MaxBandCount = 16;
  localparam int SampleWidth  = 16;
  localparam int CoefFracBits = 24;
  localparam int BandBits     = $clog2(MaxBandCount);
  localparam int EntryBits    = BandBits + 2;
  localparam int NumEntries   = MaxBandCount * 4;
  localparam int ValW         = 48;
  localparam int SampleShift  = CoefFracBits - SampleWidth + 1;

  localparam logic signed [ValW-1:0] SatPos = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] SatNeg = -SatPos;

  // register indexes
  localparam logic [1:0] RegWetGain   = 2'd0;
  localparam logic [1:0] RegMixGain   = 2'd1;
  localparam logic [1:0] RegBandCount = 2'd2;

  // coefficient selects
  localparam logic [1:0] CoefC     = 2'd0;
  localparam logic [1:0] CoefF     = 2'd1;
  localparam logic [1:0] CoefAtt   = 2'd2;
  localparam logic [1:0] CoefDecay = 2'd3;

  typedef struct packed {
    logic                          mode;
    logic signed [SampleWidth-1:0] carrier_sample;
    logic signed [SampleWidth-1:0] formant_sample;
    logic signed [SampleWidth-1:0] dry_sample;
    logic [3:0]                    band_index;
    logic [1:0]                    coef_select;
    logic [31:0]                   coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] mixed_sample;
    logic                          saturated;
  } out_item_t;

  // saturating add of two 48-bit values
  function automatic logic signed [ValW-1:0] sat_add(input logic signed [ValW-1:0] a,
                                                     input logic signed [ValW-1:0] b);
    logic signed [ValW:0] s;
    s = $signed({a[ValW-1], a}) + $signed({b[ValW-1], b});
    if (s > $signed({1'b0, SatPos})) return SatPos;
    if (s < $signed({1'b1, SatNeg})) return SatNeg;
    return s[ValW-1:0];
  endfunction

  function automatic logic signed [ValW-1:0] sat_sub(input logic signed [ValW-1:0] a,
                                                     input logic signed [ValW-1:0] b);
    logic signed [ValW:0] s;
    s = $signed({a[ValW-1], a}) - $signed({b[ValW-1], b});
    if (s > $signed({1'b0, SatPos})) return SatPos;
    if (s < $signed({1'b1, SatNeg})) return SatNeg;
    return s[ValW-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cvf_ram.sv @@
// cvf_ram: generic single-port-write, single-read synchronous RAM with registered read
// no dependencies
`default_nettype none
module cvf_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ hw/rtl/cvf_mul.sv @@
// cvf_mul: sign-magnitude 48x48 multiplier with right shift and 48-bit saturation,
// built from 24x24 partial products accumulated in turn; uses cvf_pkg
`default_nettype none
module cvf_mul
  import cvf_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [ValW-1:0] a_i,
  input  wire logic signed [ValW-1:0] b_i,
  input  wire logic [4:0]             sh_i,
  output      logic                   done_o,
  output      logic signed [ValW-1:0] p_o
);
  localparam int HalfW = ValW / 2;

  logic [ValW-1:0]   ua_q, ub_q;
  logic              neg_q;
  logic [4:0]        sh_q;
  logic [2*ValW-1:0] acc_q;
  logic [1:0]        step_q;
  logic              busy_q;
  logic [2*HalfW-1:0] pp;
  logic [HalfW-1:0]  opa, opb;
  logic [2*ValW-1:0] acc_d, shifted;
  logic [ValW-1:0]   mag;

  // one partial product per cycle
  always_comb begin
    opa = step_q[0] ? ua_q[ValW-1:HalfW] : ua_q[HalfW-1:0];
    opb = step_q[1] ? ub_q[ValW-1:HalfW] : ub_q[HalfW-1:0];
    pp  = opa * opb;
    acc_d = acc_q + ((2*ValW)'(pp) << (HalfW * (32'(step_q[0]) + 32'(step_q[1]))));
    shifted = acc_q >> sh_q;
    if (shifted > (2*ValW)'(SatPos)) mag = SatPos;
    else mag = shifted[ValW-1:0];
    p_o = neg_q ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // operand capture and accumulation
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= a_i[ValW-1] ? ValW'(-a_i) : ValW'(a_i);
      ub_q  <= b_i[ValW-1] ? ValW'(-b_i) : ValW'(b_i);
      neg_q <= a_i[ValW-1] ^ b_i[ValW-1];
      sh_q  <= sh_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/channel_vocoder_filterbank.sv @@
// channel_vocoder_filterbank: top level of the vocoder filter bank
// depends on cvf_pkg, cvf_ram, cvf_mul
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/stall   | in_item_t
//  out     | output    | out_valid/stall  | out_item_t
//  cfg     | input     | cfg_valid/ready  | index + data
//
// a sample transaction runs band_count bands of twelve ops each, every
// multiply going through one shared multiplier, then the final mix. a load
// transaction writes the coefficient and clears the four state words of its
// band. after reset a clearing pass zeroes the filter and envelope RAMs
// before the first input is taken. the next input may be taken while a
// result is stalled; its final mix then waits until the output is free.
`default_nettype none
module channel_vocoder_filterbank
  import cvf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire in_item_t   in_data_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      out_item_t  out_data_o,
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  typedef enum logic [11:0] {
    StClear = 12'b000000000001,
    StIdle  = 12'b000000000010,
    StLoad  = 12'b000000000100,
    StRdA   = 12'b000000001000,
    StRdB   = 12'b000000010000,
    StOp    = 12'b000000100000,
    StMulW  = 12'b000001000000,
    StWb    = 12'b000010000000,
    StMix   = 12'b000100000000,
    StMixW  = 12'b001000000000,
    StOut   = 12'b010000000000,
    StOutW  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [15:0] wet_q;
  logic [22:0] mix_q;
  logic [4:0]  cnt_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wet_q <= '0;
      mix_q <= 23'd65536;
      cnt_q <= 5'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWetGain:   wet_q <= cfg_data_i[15:0];
        RegMixGain:   mix_q <= cfg_data_i[22:0];
        RegBandCount: cnt_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // memories
  logic                 coef_we;
  logic [EntryBits-1:0] coef_waddr, coef_raddr;
  logic [31:0]          coef_wdata, coef_rdata;
  logic                 cst_we, fst_we, env_we;
  logic [EntryBits-1:0] st_waddr, st_raddr;
  logic [ValW-1:0]      cst_wdata, fst_wdata, cst_rdata, fst_rdata;
  logic [BandBits-1:0]  env_waddr, env_raddr;
  logic [ValW-1:0]      env_wdata, env_rdata;

  cvf_ram #(.Width(32), .Depth(NumEntries)) u_coef (
    .clk_i, .we_i(coef_we), .waddr_i(coef_waddr), .wdata_i(coef_wdata),
    .raddr_i(coef_raddr), .rdata_o(coef_rdata));
  cvf_ram #(.Width(ValW), .Depth(NumEntries)) u_cst (
    .clk_i, .we_i(cst_we), .waddr_i(st_waddr), .wdata_i(cst_wdata),
    .raddr_i(st_raddr), .rdata_o(cst_rdata));
  cvf_ram #(.Width(ValW), .Depth(NumEntries)) u_fst (
    .clk_i, .we_i(fst_we), .waddr_i(st_waddr), .wdata_i(fst_wdata),
    .raddr_i(st_raddr), .rdata_o(fst_rdata));
  cvf_ram #(.Width(ValW), .Depth(MaxBandCount)) u_env (
    .clk_i, .we_i(env_we), .waddr_i(env_waddr), .wdata_i(env_wdata),
    .raddr_i(env_raddr), .rdata_o(env_rdata));

  // shared multiplier
  logic                   mul_start, mul_done;
  logic signed [ValW-1:0] mul_a, mul_b, mul_p;
  logic [4:0]             mul_sh;
  cvf_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .sh_i(mul_sh), .done_o(mul_done), .p_o(mul_p));

  // per-band microprogram: each op reads up to two words then computes
  // working registers
  localparam int OpBits = 5;
  logic [OpBits-1:0]     op_q;
  logic [BandBits-1:0]   band_q;
  logic [EntryBits-1:0]  clr_q;
  logic [BandBits:0]     nb_q;
  logic signed [ValW-1:0] xc_q, xf_q, dry_q;
  logic signed [ValW-1:0] acc_q, yc_q, yf_q, tmp_q, hi_q, s0_q, s1_q;
  logic [31:0]           ld_val_q;
  logic [EntryBits-1:0]  ld_addr_q;
  logic                  side_q; // 0 carrier, 1 formant
  logic [1:0]            ldk_q;

  logic in_fire;
  assign in_stall_o = !(state_q == StIdle);
  assign in_fire = in_valid_i && !in_stall_o;

  // state words of current filter side
  logic signed [ValW-1:0] st_rd;
  assign st_rd = side_q ? $signed(fst_rdata) : $signed(cst_rdata);

  // high-pass term of the stage being run, from the word read for this op
  logic signed [ValW-1:0] hi_c;
  assign hi_c = (op_q == 5'd1) ? sat_sub(sat_sub(side_q ? xf_q : xc_q, tmp_q), st_rd) :
                                 sat_sub(sat_sub(s0_q, tmp_q), st_rd);

  // op list per side (op index in op_q):
  //  0: read f, p1  -> mul f*p1
  //  1: hi = (x - m) - p0 (read p0) ; read c -> mul hi*c
  //  2: p1 += m, p0 += p1 (write p1, p0) ; read f, p3 -> mul f*p3
  //  3: hi = (p0 - m) - p2 ; read c -> mul hi*c
  //  4: p3 += m, p2 += p3 ; read att -> mul hi*att -> y
  //  5: envelope step; 6: acc += yc * env (formant side end)
  logic [1:0] rd_k;
  logic [1:0] rd_c;
  always_comb begin
    rd_k = 2'd0;
    rd_c = CoefF;
    case (op_q)
      5'd0: begin rd_k = 2'd1; rd_c = CoefF; end
      5'd1: begin rd_k = 2'd0; rd_c = CoefC; end
      5'd2: begin rd_k = 2'd3; rd_c = CoefF; end
      5'd3: begin rd_k = 2'd2; rd_c = CoefC; end
      5'd4: begin rd_k = 2'd2; rd_c = CoefAtt; end
      5'd5: begin rd_k = 2'd0; rd_c = CoefDecay; end
      5'd6: begin rd_k = 2'd0; rd_c = CoefDecay; end
      default: ;
    endcase
  end
  assign st_raddr   = {band_q, rd_k};
  assign coef_raddr = {band_q, rd_c};
  assign env_raddr  = band_q;

  logic signed [ValW-1:0] absyf, lim;
  localparam logic signed [ValW-1:0] Lim = ValW'(64'sd1 << (CoefFracBits + 1));
  localparam logic signed [ValW-1:0] SMax = ValW'((64'sd1 <<< (SampleWidth - 1)) - 1);
  localparam logic signed [ValW-1:0] SMin = -ValW'(64'sd1 <<< (SampleWidth - 1));
  assign absyf = yf_q[ValW-1] ? -yf_q : yf_q;
  assign lim = Lim;

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_sh    = 5'(CoefFracBits);
    coef_we   = 1'b0;
    coef_waddr = ld_addr_q;
    coef_wdata = ld_val_q;
    cst_we = 1'b0; fst_we = 1'b0; env_we = 1'b0;
    st_waddr = {band_q, 2'd0};
    cst_wdata = '0; fst_wdata = '0;
    env_waddr = band_q; env_wdata = '0;
    case (state_q)
      StClear: begin
        cst_we = 1'b1; fst_we = 1'b1;
        st_waddr = clr_q;
        env_we = 1'b1; env_waddr = clr_q[BandBits-1:0];
        if (clr_q == EntryBits'(NumEntries - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (in_fire) begin
          if (in_data_i.mode) state_d = StLoad;
          else state_d = StRdA;
        end
      end
      StLoad: begin
        // write coefficient then clear four state words, one per cycle
        if (ldk_q == 2'd0) coef_we = 1'b1;
        cst_we = 1'b1; fst_we = 1'b1;
        st_waddr = {ld_addr_q[EntryBits-1:2], ldk_q};
        if (ldk_q == 2'd3) state_d = StIdle;
      end
      StRdA: state_d = StOp; // address set, wait for read data
      StOp: begin
        mul_start = 1'b1;
        state_d = StMulW;
        case (op_q)
          5'd0: begin mul_a = $signed(ValW'(coef_rdata)); mul_b = st_rd; end
          5'd1: begin mul_a = hi_c; mul_b = $signed(ValW'(coef_rdata)); end
          5'd2: begin mul_a = $signed(ValW'(coef_rdata)); mul_b = st_rd; end
          5'd3: begin mul_a = hi_c; mul_b = $signed(ValW'(coef_rdata)); end
          5'd4: begin mul_a = hi_q; mul_b = $signed(ValW'(coef_rdata)); end
          5'd5: begin
            mul_a = sat_sub(absyf, $signed(env_rdata));
            mul_b = $signed(ValW'(coef_rdata));
          end
          default: begin mul_a = yc_q; mul_b = tmp_q; end
        endcase
      end
      StMulW: if (mul_done) state_d = StWb;
      StWb: begin
        state_d = StRdA;
        case (op_q)
          5'd1: begin
            cst_we = !side_q; fst_we = side_q;
            st_waddr = {band_q, 2'd1};
            cst_wdata = sat_add(s1_q, mul_p); fst_wdata = sat_add(s1_q, mul_p);
          end
          5'd2: begin
            cst_we = !side_q; fst_we = side_q;
            st_waddr = {band_q, 2'd0};
            cst_wdata = s0_q; fst_wdata = s0_q;
          end
          5'd3: begin
            cst_we = !side_q; fst_we = side_q;
            st_waddr = {band_q, 2'd3};
            cst_wdata = sat_add(s1_q, mul_p); fst_wdata = sat_add(s1_q, mul_p);
          end
          5'd4: begin
            cst_we = !side_q; fst_we = side_q;
            st_waddr = {band_q, 2'd2};
            cst_wdata = s0_q; fst_wdata = s0_q;
          end
          5'd5: begin
            env_we = 1'b1;
            env_wdata = sat_add($signed(env_rdata), mul_p);
          end
          5'd6: begin
            if (BandBits'(band_q) == BandBits'(nb_q - 1'b1) || nb_q == 1)
              state_d = StMix;
          end
          default: ;
        endcase
      end
      StMix: begin
        // hold until the previous result has left the output register
        mul_a = dry_q; mul_b = $signed(ValW'(wet_q)); mul_sh = 5'd15;
        if (!out_valid_o) begin
          mul_start = 1'b1;
          state_d = StMixW;
        end
      end
      StMixW: if (mul_done) state_d = StOut;
      StOut: begin
        mul_start = 1'b1;
        mul_a = acc_q; mul_b = $signed(ValW'(mix_q)); mul_sh = 5'd16;
        state_d = StOutW;
      end
      StOutW: begin
        if (mul_done) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // final mix and saturation
  logic signed [ValW-1:0] sum_c, s_c;
  logic                   clip_c;
  logic signed [15:0]     smp_c;
  always_comb begin
    sum_c = sat_add(tmp_q, mul_p);
    if (sum_c > lim) sum_c = lim;
    if (sum_c < -lim) sum_c = -lim;
    s_c = sum_c >>> SampleShift;
    clip_c = 1'b0;
    if (s_c > SMax) begin s_c = SMax; clip_c = 1'b1; end
    if (s_c < SMin) begin s_c = SMin; clip_c = 1'b1; end
    smp_c = s_c[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_o <= 1'b0;
      op_q        <= '0;
      band_q      <= '0;
      side_q      <= 1'b0;
      ldk_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        StClear: clr_q <= clr_q + 1'b1;
        StIdle: begin
          op_q <= '0; band_q <= '0; side_q <= 1'b0; ldk_q <= '0;
        end
        StLoad: ldk_q <= ldk_q + 2'd1;
        StWb: begin
          // sequence: carrier ops 0..4, formant ops 0..4, then 5, 6
          if (op_q == 5'd4 && !side_q) begin
            side_q <= 1'b1; op_q <= '0;
          end else if (op_q == 5'd6) begin
            op_q <= '0; side_q <= 1'b0; band_q <= band_q + 1'b1;
          end else begin
            op_q <= op_q + 1'b1;
          end
        end
        StOutW: if (mul_done) out_valid_o <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      xc_q  <= ValW'(in_data_i.carrier_sample) <<< SampleShift;
      xf_q  <= ValW'(in_data_i.formant_sample) <<< SampleShift;
      dry_q <= ValW'(in_data_i.dry_sample) <<< SampleShift;
      acc_q <= '0;
      ld_val_q  <= in_data_i.coef_value;
      ld_addr_q <= {in_data_i.band_index[BandBits-1:0], in_data_i.coef_select};
      nb_q <= (cnt_q == 5'd0) ? (BandBits+1)'(1) :
              (cnt_q > 5'(MaxBandCount)) ? (BandBits+1)'(MaxBandCount) :
              (BandBits+1)'(cnt_q);
    end
    if (state_q == StOp) begin
      // capture state words seen at this op
      case (op_q)
        5'd0: s1_q <= st_rd;
        5'd2: s1_q <= st_rd;
        5'd5: tmp_q <= tmp_q;
        default: ;
      endcase
    end
    if (state_q == StWb) begin
      case (op_q)
        5'd0: begin
          // need p0: it is read in op 1; compute high after that read
          tmp_q <= mul_p;
        end
        5'd1: begin
          s0_q <= sat_add(s0_q, sat_add(s1_q, mul_p));
          s1_q <= sat_add(s1_q, mul_p);
        end
        5'd2: tmp_q <= mul_p;
        5'd3: begin
          s0_q <= sat_add(s0_q, sat_add(s1_q, mul_p));
        end
        5'd4: begin
          if (side_q) yf_q <= mul_p; else yc_q <= mul_p;
        end
        5'd5: tmp_q <= sat_add($signed(env_rdata), mul_p);
        5'd6: acc_q <= sat_add(acc_q, mul_p);
        default: ;
      endcase
    end
    // state reads arriving for ops that need a second word
    if (state_q == StOp) begin
      case (op_q)
        5'd1: begin
          s0_q <= st_rd;
          hi_q <= hi_c;
        end
        5'd2: ;
        5'd3: begin
          hi_q <= hi_c;
          s0_q <= st_rd;
          tmp_q <= s0_q;
        end
        default: ;
      endcase
    end
    if (state_q == StMixW && mul_done) tmp_q <= mul_p;
    if (state_q == StOutW && mul_done) begin
      out_data_o.mixed_sample <= smp_c;
      out_data_o.saturated    <= clip_c;
    end
  end
endmodule
`default_nettype wire
